/* sv/kdpc_pkg.sv */
// ----------------------------------------------------------------------------
// kdpc_pkg
// Shared types and constants for the key debounce and press classifier.
// ----------------------------------------------------------------------------
package kdpc_pkg;

   localparam int NUM_KEYS = 3;
   localparam int KEY_W    = 3;
   localparam int CNT_W    = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   // Pressed-key code mask derived from the number of keys wired up.
   localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((1 << NUM_KEYS) - 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS = CSR_IDX_W'(1);

   localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST   = CNT_W'(2);
   localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = CNT_W'(200);

   // Event kinds.
   localparam logic EVENT_SHORT = 1'b0;
   localparam logic EVENT_LONG  = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_SHORT = 2'd1,
      MODE_LONG  = 2'd2
   } press_mode_type;

endpackage

/* sv/key_debounce_press_classifier.sv */
// ----------------------------------------------------------------------------
// key_debounce_press_classifier
// Debounces three active-low keys and reports short and long presses.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   req_key_pins
//  rsp      out        rsp_valid/rsp_stall   rsp_event_valid/kind/keys
//  csr      in         csr_valid/csr_ready   csr_index/csr_wdata
//
// One item is taken per clock when not stalled; its result is registered and
// shows in the next cycle. The result register is the only buffer: a new item
// is taken while it is empty or its item is being delivered in the same
// cycle. Reset is synchronous and restores the configuration and press state
// defaults. Configuration writes are always ready and take effect on the next
// item.
module key_debounce_press_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kdpc_pkg::KEY_W-1:0]          req_key_pins,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_event_valid,
   output logic                                rsp_event_kind,
   output logic [kdpc_pkg::KEY_W-1:0]          rsp_event_keys,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kdpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kdpc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [kdpc_pkg::CNT_W-1:0]  debounce_ticks_ff;
   logic [kdpc_pkg::CNT_W-1:0]  long_press_ticks_ff;

   logic [kdpc_pkg::KEY_W-1:0]  last_code_ff, last_code_in;
   logic [kdpc_pkg::CNT_W-1:0]  stable_count_ff, stable_count_in;
   kdpc_pkg::press_mode_type    press_mode_ff, press_mode_in;
   logic [kdpc_pkg::KEY_W-1:0]  held_code_ff, held_code_in;

   logic                        rsp_valid_ff;
   logic                        event_valid_ff, event_valid_in;
   logic                        event_kind_ff, event_kind_in;
   logic [kdpc_pkg::KEY_W-1:0]  event_keys_ff, event_keys_in;

   logic                        req_accept;
   logic [kdpc_pkg::KEY_W-1:0]  code;
   logic [kdpc_pkg::CNT_W-1:0]  count_inc;
   logic                        is_changed;
   logic                        is_counting;
   logic                        at_debounce;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   assign code        = ~req_key_pins & kdpc_pkg::KEY_MASK;
   assign count_inc   = stable_count_ff + kdpc_pkg::CNT_W'(1);
   assign is_changed  = (code != last_code_ff);
   assign is_counting = (stable_count_ff < long_press_ticks_ff);
   assign at_debounce = (count_inc == debounce_ticks_ff);

   // Next press state.
   always_comb begin
      last_code_in    = last_code_ff;
      stable_count_in = stable_count_ff;
      press_mode_in   = press_mode_ff;
      held_code_in    = held_code_ff;
      if (is_changed) begin
         stable_count_in = '0;
         last_code_in    = code;
      end else if (is_counting) begin
         stable_count_in = count_inc;
         if (at_debounce) begin
            if (code == '0) begin
               // A stable release ends the press and restarts the count.
               stable_count_in = '0;
               press_mode_in   = kdpc_pkg::MODE_IDLE;
               held_code_in    = '0;
            end else begin
               press_mode_in = kdpc_pkg::MODE_SHORT;
               if (held_code_ff < code) begin
                  held_code_in = code;
               end
            end
         end
      end else if (press_mode_ff != kdpc_pkg::MODE_LONG) begin
         press_mode_in = kdpc_pkg::MODE_LONG;
      end
   end

   // Event of the current item.
   always_comb begin
      event_valid_in = 1'b0;
      event_kind_in  = kdpc_pkg::EVENT_SHORT;
      event_keys_in  = '0;
      if (!is_changed) begin
         if (is_counting) begin
            if (at_debounce && (code == '0) && (press_mode_ff == kdpc_pkg::MODE_SHORT)) begin
               event_valid_in = 1'b1;
               event_kind_in  = kdpc_pkg::EVENT_SHORT;
               event_keys_in  = held_code_ff;
            end
         end else if (press_mode_ff != kdpc_pkg::MODE_LONG) begin
            event_valid_in = 1'b1;
            event_kind_in  = kdpc_pkg::EVENT_LONG;
            event_keys_in  = held_code_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= kdpc_pkg::DEBOUNCE_TICKS_RST;
         long_press_ticks_ff <= kdpc_pkg::LONG_PRESS_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kdpc_pkg::CSR_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_wdata;
            kdpc_pkg::CSR_LONG_PRESS_TICKS: long_press_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_code_ff    <= '0;
         stable_count_ff <= '0;
         press_mode_ff   <= kdpc_pkg::MODE_IDLE;
         held_code_ff    <= '0;
      end else if (req_accept) begin
         last_code_ff    <= last_code_in;
         stable_count_ff <= stable_count_in;
         press_mode_ff   <= press_mode_in;
         held_code_ff    <= held_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         event_valid_ff <= event_valid_in;
         event_kind_ff  <= event_kind_in;
         event_keys_ff  <= event_keys_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_valid = event_valid_ff;
   assign rsp_event_kind  = event_kind_ff;
   assign rsp_event_keys  = event_keys_ff;

   // The input side only waits behind a held result.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no result pending");

   // A long event moves the press into the long mode.
   a_long_sets_mode: assert property (@(posedge clock) disable iff (reset)
      (req_accept && event_valid_in && (event_kind_in == kdpc_pkg::EVENT_LONG))
      |=> (press_mode_ff == kdpc_pkg::MODE_LONG))
      else $error("long event without entering long mode");

   // An idle press keeps no code.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (press_mode_ff == kdpc_pkg::MODE_IDLE) |-> (held_code_ff == '0))
      else $error("held code kept while idle");

   // Result items without an event carry zero fields.
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_event_valid) |-> (!rsp_event_kind && (rsp_event_keys == '0)))
      else $error("nonzero fields without an event");

endmodule
